FILE: hw/rtl/bap_pkg.sv
package bap_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_BLOCK_DEF = 200;

    localparam int SUM_W  = 24;
    localparam int FADE_W = 17;
    localparam int CFG_W  = 17;
    localparam int CNT_W  = 18;                   // block_w * block_h, up to 255 * 255
    localparam int NUM_W  = SUM_W + FADE_W - 16;  // (sum * fade) >> 16
    localparam int LANES  = 4;

    localparam logic [16:0] FADE_ONE = 17'd65536;
    localparam logic [12:0] ROW_LIMIT = 13'd4096;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [7:0]  BLOCK_SIZE_RST   = 8'd1;
    localparam logic [16:0] FADE_SCALE_RST   = 17'd65536;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BLOCK_SIZE   = 2'd2,
        CFG_FADE_SCALE   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef logic [NUM_W-1:0] dnum_t;
    typedef logic [7:0]       quot_t;

endpackage

FILE: hw/rtl/bap_ram.sv
module bap_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/bap_div.sv
// Four-lane restoring divider, one quotient bit per cycle.
// First step only checks for overflow (quotient >= 256 saturates to 255).
module bap_div
    import bap_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [CNT_W-1:0]       count,
    input  dnum_t [LANES-1:0]      num,
    output logic                   done,
    output quot_t [LANES-1:0]      quot
);

    logic                   busy_reg, busy_next;
    logic [3:0]             step_reg, step_next;
    logic                   done_reg, done_next;
    logic [CNT_W+7:0]       dvs_reg;
    dnum_t [LANES-1:0]      rem_reg;
    quot_t [LANES-1:0]      q_reg;
    logic  [LANES-1:0]      sat_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd8;
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= {count, 8'd0};
            rem_reg <= num;
            q_reg   <= '0;
            sat_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvs_reg <= dvs_reg >> 1;
            for (int i = 0; i < LANES; i++)
            begin
                if ({{(CNT_W+8-NUM_W){1'b0}}, rem_reg[i]} >= dvs_reg)
                begin
                    rem_reg[i] <= rem_reg[i] - dvs_reg[NUM_W-1:0];
                    if (step_reg[3])
                    begin
                        sat_reg[i] <= 1'b1;
                    end
                    else
                    begin
                        q_reg[i][step_reg[2:0]] <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            quot[i] = sat_reg[i] ? 8'hFF : q_reg[i];
        end
    end

    assign done = done_reg;

endmodule

FILE: hw/rtl/block_average_pixelate.sv
// channel   direction   handshake              payload
// in        input       in_valid / in_stall    red, green, blue, opacity
// out       output      out_valid / out_stall  block_x .. avg_opacity, frame_done
// cfg       input       cfg_we                 cfg_index, cfg_data
//
// A word that closes no block is accepted with the sum RAM read, then goes
// through the read-modify-write. A block-closing word adds the multiply step,
// the divider and the load of the output register.
// rst_n clears control and loads register defaults; the sum RAM is not cleared,
// the first pixel of each block overwrites its entry.
// in_stall is high while a word is in work; out_stall only holds the last step.
module block_average_pixelate
    import bap_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    input  logic [7:0]        opacity,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [11:0]       block_x,
    output logic [11:0]       block_y,
    output logic [7:0]        block_w,
    output logic [7:0]        block_h,
    output logic [7:0]        avg_red,
    output logic [7:0]        avg_green,
    output logic [7:0]        avg_blue,
    output logic [7:0]        avg_opacity,
    output logic              frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RAM_W = LANES * SUM_W;

    state_t state_reg, state_next;

    logic [12:0]       fw_reg, fh_reg;
    logic [7:0]        bsz_reg;
    logic [16:0]       fade_reg;

    logic [COL_W-1:0]  pcol_reg, pcol_next;
    logic [11:0]       prow_reg, prow_next;
    logic [7:0]        cib_reg, cib_next;
    logic [7:0]        rib_reg, rib_next;

    logic              accept;
    logic [COL_W-1:0]  start_c;
    logic [11:0]       top_c;
    logic [31:0]       w_eff, h_eff, bs_eff;
    logic              row_end, frame_end, last_col, last_row;
    logic [16:0]       fade_eff;

    // word held through the update
    logic [COL_W-1:0]  addr_reg;
    logic [11:0]       top_reg;
    logic [8:0]        bw_reg, bh_reg;
    logic              first_reg, emit_reg, fdone_reg;
    logic [7:0]        px_reg [LANES];
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg [LANES];

    logic [RAM_W-1:0]  rd_data, wr_data;
    logic              ram_we;
    logic              div_start, div_done;
    dnum_t [LANES-1:0] div_num;
    quot_t [LANES-1:0] div_q;
    logic              out_free, out_load;
    logic              out_valid_reg;
    logic [COL_W+11:0] bx_ext;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= FRAME_WIDTH_RST;
            fh_reg   <= FRAME_HEIGHT_RST;
            bsz_reg  <= BLOCK_SIZE_RST;
            fade_reg <= FADE_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  fw_reg   <= cfg_data[12:0];
                CFG_FRAME_HEIGHT: fh_reg   <= cfg_data[12:0];
                CFG_BLOCK_SIZE:   bsz_reg  <= cfg_data[7:0];
                CFG_FADE_SCALE:   fade_reg <= cfg_data[16:0];
                default:          ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    always_comb
    begin
        w_eff  = (fw_reg == 13'd0) ? 32'd1 :
                 (32'(fw_reg) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(fw_reg);
        h_eff  = (fh_reg == 13'd0) ? 32'd1 :
                 (fh_reg > ROW_LIMIT) ? 32'(ROW_LIMIT) : 32'(fh_reg);
        bs_eff = (bsz_reg == 8'd0) ? 32'd1 :
                 (32'(bsz_reg) > MAX_BLOCK) ? 32'(MAX_BLOCK) : 32'(bsz_reg);
        fade_eff = (fade_reg > FADE_ONE) ? FADE_ONE : fade_reg;

        start_c = (32'(pcol_reg) >= 32'(cib_reg)) ?
                  COL_W'(32'(pcol_reg) - 32'(cib_reg)) : '0;
        top_c   = (prow_reg >= 12'(rib_reg)) ? (prow_reg - 12'(rib_reg)) : 12'd0;

        row_end   = (32'(pcol_reg) + 32'd1) >= w_eff;
        frame_end = (32'(prow_reg) + 32'd1) >= h_eff;
        last_col  = row_end || ((32'(cib_reg) + 32'd1) >= bs_eff);
        last_row  = frame_end || ((32'(rib_reg) + 32'd1) >= bs_eff);

        pcol_next = pcol_reg;
        prow_next = prow_reg;
        cib_next  = cib_reg;
        rib_next  = rib_reg;
        if (accept)
        begin
            if (row_end)
            begin
                pcol_next = '0;
                cib_next  = 8'd0;
                rib_next  = last_row ? 8'd0 : rib_reg + 8'd1;
                prow_next = frame_end ? 12'd0 : prow_reg + 12'd1;
            end
            else
            begin
                pcol_next = pcol_reg + COL_W'(1);
                cib_next  = last_col ? 8'd0 : cib_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg <= '0;
            prow_reg <= 12'd0;
            cib_reg  <= 8'd0;
            rib_reg  <= 8'd0;
        end
        else
        begin
            pcol_reg <= pcol_next;
            prow_reg <= prow_next;
            cib_reg  <= cib_next;
            rib_reg  <= rib_next;
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_we     = 1'b1;
                state_next = emit_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- sum memory ----------------
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            wr_data[i*SUM_W +: SUM_W] = first_reg ? SUM_W'(px_reg[i]) :
                rd_data[i*SUM_W +: SUM_W] + SUM_W'(px_reg[i]);
        end
    end

    bap_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (start_c),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= start_c;
            top_reg   <= top_c;
            bw_reg    <= 9'(cib_reg) + 9'd1;
            bh_reg    <= 9'(rib_reg) + 9'd1;
            first_reg <= (cib_reg == 8'd0) && (rib_reg == 8'd0);
            emit_reg  <= last_col && last_row;
            fdone_reg <= row_end && frame_end;
            px_reg[0] <= red;
            px_reg[1] <= green;
            px_reg[2] <= blue;
            px_reg[3] <= opacity;
        end
        if (ram_we)
        begin
            count_reg <= CNT_W'(bw_reg) * CNT_W'(bh_reg);
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= wr_data[i*SUM_W +: SUM_W];
            end
        end
    end

    // ---------------- fade and mean ----------------
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            div_num[i] = NUM_W'((41'(sum_reg[i]) * 41'(fade_eff)) >> 16);
        end
    end

    bap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .count (count_reg),
        .num   (div_num),
        .done  (div_done),
        .quot  (div_q)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign bx_ext = (COL_W+12)'(addr_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            block_x     <= bx_ext[11:0];
            block_y     <= top_reg;
            block_w     <= bw_reg[7:0];
            block_h     <= bh_reg[7:0];
            avg_red     <= div_q[0];
            avg_green   <= div_q[1];
            avg_blue    <= div_q[2];
            avg_opacity <= div_q[3];
            frame_done  <= fdone_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
